### design/lki_pkg.sv
`timescale 1ns / 1ps
package lki_pkg;
    localparam int DEPTH = 16;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NO_PAIR = 3'd1;
    localparam logic [2:0] ST_EMPTY   = 3'd2;
    localparam logic [2:0] ST_FULL    = 3'd3;
    localparam logic [2:0] ST_DUP     = 3'd4;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    typedef struct packed {
        logic              operation;
        logic [15:0]       key_time;
        logic signed [15:0] key_value;
    } t_in;

    typedef struct packed {
        logic signed [15:0] result_value;
        logic [2:0]         status;
    } t_out;
endpackage

### design/lki_ram.sv
`timescale 1ns / 1ps
module lki_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### design/lki_div.sv
`timescale 1ns / 1ps
// Unsigned restoring divider, one quotient bit per cycle.
module lki_div (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [31:0] i_num,
    input  logic [16:0] i_den,
    output logic        o_done,
    output logic [31:0] o_quo,
    output logic [16:0] o_rem
);
    logic [31:0] r_quo;
    logic [17:0] r_rem;
    logic [16:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_busy;
    logic [17:0] n_shift;

    assign n_shift = {r_rem[16:0], r_quo[31]};
    assign o_quo = r_quo;
    assign o_rem = r_rem[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 6'd32;
                r_quo  <= i_num;
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                if (n_shift >= {1'b0, r_den}) begin
                    r_rem <= n_shift - {1'b0, r_den};
                    r_quo <= {r_quo[30:0], 1'b1};
                end else begin
                    r_rem <= n_shift;
                    r_quo <= {r_quo[30:0], 1'b0};
                end
                r_cnt <= r_cnt - 6'd1;
                if (r_cnt == 6'd1) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
endmodule

### design/looping_keyframe_interpolator_unit.sv
`timescale 1ns / 1ps
// Looping keyframe interpolator. The block keeps up to DEPTH keyframes
// (unsigned time, signed Q8.8 value) sorted by time in one single-port-read
// RAM, and answers one word at a time. An insert scans the table entry by
// entry to find its slot. It then shifts the tail up one entry at a time
// and writes the new word into its slot. A query reads the last key time
// and wraps the query time with a serial divider. It then scans for the
// bounding pair entry by entry and runs a second division to scale the
// value step by the time offset. The serial divider and the registered RAM
// read in every step of the walk set the pace of both operations. A result
// word waits in an output register until it is taken; the next input word
// is accepted once the result of the previous one has left that register.
module looping_keyframe_interpolator_unit (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  lki_pkg::t_in      i_data,
    output logic              o_valid,
    input  logic              i_ready,
    output lki_pkg::t_out     o_data
);
    localparam int AW = lki_pkg::AW;
    localparam int CW = lki_pkg::CW;

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_SCAN  = 11'b00000000010,
        S_SCANW = 11'b00000000100,
        S_SHIFT = 11'b00000001000,
        S_SHW   = 11'b00000010000,
        S_LAST  = 11'b00000100000,
        S_MOD   = 11'b00001000000,
        S_QSCAN = 11'b00010000000,
        S_PAIR  = 11'b00100000000,
        S_DIV   = 11'b01000000000,
        S_OUT   = 11'b10000000000
    } t_state;

    t_state r_state;
    lki_pkg::t_in r_in;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic [15:0] r_eff;
    logic [15:0] r_t0;
    logic signed [15:0] r_v0;
    logic [15:0] r_tprev;
    logic signed [15:0] r_vprev;
    logic r_neg;
    logic r_first;
    logic signed [16:0] r_dv;
    lki_pkg::t_out r_out;
    logic r_ovalid;

    // RAM holds {time, value} per entry.
    logic          ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [31:0]   ram_wdata, ram_rdata;
    logic [15:0]   rd_t;
    logic signed [15:0] rd_v;

    logic        div_start, div_done;
    logic [31:0] div_num, div_quo;
    logic [16:0] div_den, div_rem;

    logic signed [33:0] prod;
    logic [16:0] dt_eff;
    logic signed [16:0] qs;

    assign rd_t = ram_rdata[31:16];
    assign rd_v = ram_rdata[15:0];

    lki_ram #(.WIDTH(32), .DEPTH(lki_pkg::DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    lki_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(div_start),
        .i_num  (div_num),
        .i_den  (div_den),
        .o_done (div_done),
        .o_quo  (div_quo),
        .o_rem  (div_rem)
    );

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;
    assign o_data  = r_out;

    // Signed product of value step and time offset (fits 34 bits).
    assign dt_eff = {1'b0, r_eff} - {1'b0, r_t0};
    assign prod = r_dv * $signed({1'b0, dt_eff});
    assign qs = r_neg ? -$signed({1'b0, div_quo[15:0]}) : $signed({1'b0, div_quo[15:0]});

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx[AW-1:0];
        ram_wdata = {r_tprev, r_vprev};
        ram_raddr = r_idx[AW-1:0];
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        unique case (r_state)
            S_SHIFT: begin
                ram_raddr = r_idx[AW-1:0] - AW'(1);
                // The slot is free: the new word goes in here.
                if (r_idx == r_t0[CW-1:0]) begin
                    ram_we = 1'b1;
                end
            end
            S_SHW: begin
                ram_we = 1'b1;
                if (r_idx == r_count) begin
                    ram_waddr = r_idx[AW-1:0];
                end
                ram_wdata = {rd_t, rd_v};
            end
            S_LAST: begin
                ram_raddr = r_idx[AW-1:0];
            end
            default: begin
            end
        endcase
        if (r_state == S_LAST && r_first) begin
            div_start = 1'b1;
            div_num   = {16'd0, r_in.key_time};
            div_den   = {1'b0, rd_t};
        end
        if (r_state == S_PAIR && r_first) begin
            div_start = 1'b1;
            div_num   = prod[33] ? 32'(-prod) : prod[31:0];
            div_den   = {1'b0, rd_t} - {1'b0, r_t0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_count  <= '0;
            r_ovalid <= 1'b0;
            r_idx    <= '0;
            r_first  <= 1'b0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_in  <= i_data;
                        if (i_data.operation == lki_pkg::OP_INSERT) begin
                            r_idx   <= '0;
                            r_out   <= '{result_value: '0, status: lki_pkg::ST_OK};
                            r_state <= S_SCAN;
                        end else if (r_count == '0) begin
                            r_out   <= '{result_value: '0, status: lki_pkg::ST_EMPTY};
                            r_state <= S_OUT;
                        end else begin
                            r_out   <= '{result_value: '0, status: lki_pkg::ST_OK};
                            r_idx   <= r_count - CW'(1);
                            r_first <= 1'b0;
                            r_state <= S_LAST;
                        end
                    end
                end
                S_SCAN: begin
                    if (r_idx == r_count) begin
                        if (r_count == CW'(lki_pkg::DEPTH)) begin
                            r_out.status <= lki_pkg::ST_FULL;
                            r_state <= S_OUT;
                        end else begin
                            r_tprev <= r_in.key_time;
                            r_vprev <= r_in.key_value;
                            r_idx   <= r_count;
                            r_t0    <= {{(16-CW){1'b0}}, r_idx};
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        r_state <= S_SCANW;
                    end
                end
                S_SCANW: begin
                    if (rd_t == r_in.key_time) begin
                        r_out.status <= lki_pkg::ST_DUP;
                        r_state <= S_OUT;
                    end else if (rd_t > r_in.key_time) begin
                        if (r_count == CW'(lki_pkg::DEPTH)) begin
                            r_out.status <= lki_pkg::ST_FULL;
                            r_state <= S_OUT;
                        end else begin
                            // Insert position held in r_t0.
                            r_t0    <= {{(16-CW){1'b0}}, r_idx};
                            r_idx   <= r_count;
                            r_tprev <= r_in.key_time;
                            r_vprev <= r_in.key_value;
                            r_state <= S_SHIFT;
                        end
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= S_SCAN;
                    end
                end
                S_SHIFT: begin
                    if (r_idx == r_t0[CW-1:0]) begin
                        // Final write of the new word at its slot.
                        r_count <= r_count + CW'(1);
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_SHW;
                    end
                end
                S_SHW: begin
                    r_idx   <= r_idx - CW'(1);
                    r_state <= S_SHIFT;
                end
                S_LAST: begin
                    if (r_first) begin
                        r_state <= S_MOD;
                        if (rd_t == 16'd0) begin
                            r_idx   <= '0;
                            r_first <= 1'b0;
                            r_eff   <= 16'hFFFF;
                        end else begin
                            r_eff   <= 16'd0;
                        end
                    end else begin
                        r_first <= 1'b1;
                    end
                end
                S_MOD: begin
                    if (r_eff == 16'hFFFF && !r_first) begin
                        // Single key at time zero: wait one read of entry zero.
                        r_first <= 1'b1;
                    end else if (r_eff == 16'hFFFF) begin
                        r_out.result_value <= rd_v;
                        r_state <= S_OUT;
                    end else if (div_done) begin
                        r_eff   <= div_rem[15:0];
                        r_idx   <= '0;
                        r_first <= 1'b0;
                        r_state <= S_QSCAN;
                    end
                end
                S_QSCAN: begin
                    r_first <= ~r_first;
                    if (r_first) begin
                        if (rd_t <= r_eff) begin
                            r_t0 <= rd_t;
                            r_v0 <= rd_v;
                            if (r_idx + CW'(1) >= r_count) begin
                                r_out.status <= lki_pkg::ST_NO_PAIR;
                                r_state <= S_OUT;
                            end
                            r_idx <= r_idx + CW'(1);
                        end else if (r_idx == '0) begin
                            r_out.status <= lki_pkg::ST_NO_PAIR;
                            r_state <= S_OUT;
                        end else begin
                            r_dv    <= 17'(rd_v) - 17'(r_v0);
                            r_state <= S_PAIR;
                        end
                    end
                end
                S_PAIR: begin
                    // The divide launches on the pass with r_first set, with r_dv registered.
                    r_first <= 1'b1;
                    if (r_first) begin
                        r_neg   <= prod[33];
                        r_state <= S_DIV;
                    end
                end
                S_DIV: begin
                    if (div_done) begin
                        r_out.result_value <= 16'(17'(r_v0) + qs);
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    r_ovalid <= 1'b1;
                    r_state  <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(lki_pkg::DEPTH))
        else $error("keyframe count exceeds depth");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (r_state == S_SHW || r_state == S_SHIFT))
        else $error("RAM written outside insert");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |=> o_valid)
        else $error("result word lost");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ready |-> !o_valid)
        else $error("input taken while result pending");
endmodule
